### rtl/csvtok_pkg.sv
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Shared types, character codes, result kinds and register indexes of the
// CSV field tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE        = 2'd0;
  localparam logic [1:0] KIND_FIELD_END   = 2'd1;
  localparam logic [1:0] KIND_RECORD_END  = 2'd2;
  localparam logic [1:0] KIND_QUOTE_ERROR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_DELIMITER = 2'd0;
  localparam logic [1:0] REG_QUOTE     = 2'd1;
  localparam logic [1:0] REG_ESCAPE    = 2'd2;

  // Register reset values.
  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;
  localparam logic [7:0] ESCAPE_RESET    = 8'd92;

  // Control characters.
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_char;
    logic [7:0] escape_char;
  } tok_cfg_t;

  typedef struct packed {
    logic       inside_quotes;
    logic       at_field_start;
    logic       held_valid;
    logic [7:0] held_byte;
    logic       after_cr;
    logic       line_not_empty;
  } tok_state_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    inside_quotes:  1'b0,
    at_field_start: 1'b1,
    held_valid:     1'b0,
    held_byte:      8'h00,
    after_cr:       1'b0,
    line_not_empty: 1'b0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } res_item_t;

  // Up to two results produced by one input beat.
  typedef struct packed {
    logic [1:0] count;
    res_item_t  item0;
    res_item_t  item1;
  } res_pair_t;

endpackage

### rtl/csvtok_step.sv
// ----------------------------------------------------------------------------
// CSV tokenizer step logic
// Combinational next-state and result logic for one input beat: line-end
// handling, quote and escape lookahead, delimiter detection.
// ----------------------------------------------------------------------------
module csvtok_step
  import csvtok_pkg::*;
(
  input  tok_cfg_t   cfg,
  input  tok_state_t st,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output tok_state_t state_next,
  output res_pair_t  res
);

  typedef struct packed {
    tok_state_t st;
    res_pair_t  res;
  } tok_ctx_t;

  // Append one result to the pair.
  function automatic tok_ctx_t push(tok_ctx_t c, logic [1:0] k, logic [7:0] v);
    tok_ctx_t r;
    r = c;
    if (c.res.count == 2'd0) begin
      r.res.item0.kind  = k;
      r.res.item0.value = v;
      r.res.count       = 2'd1;
    end else if (c.res.count == 2'd1) begin
      r.res.item1.kind  = k;
      r.res.item1.value = v;
      r.res.count       = 2'd2;
    end
    return r;
  endfunction

  // An ordinary byte: delimiter outside quotes ends the field.
  function automatic tok_ctx_t plain_byte(tok_ctx_t c, tok_cfg_t g, logic [7:0] b);
    tok_ctx_t r;
    r = c;
    r.st.at_field_start = 1'b0;
    if (b == g.delimiter_char && !c.st.inside_quotes) begin
      r = push(r, KIND_FIELD_END, 8'h00);
      r.st.at_field_start = 1'b1;
    end else begin
      r = push(r, KIND_BYTE, b);
    end
    return r;
  endfunction

  // A quote not followed by another quote.
  function automatic tok_ctx_t lone_quote(tok_ctx_t c, logic [7:0] q);
    tok_ctx_t r;
    r = c;
    if (c.st.inside_quotes) begin
      r.st.inside_quotes = 1'b0;
    end else if (c.st.at_field_start) begin
      r.st.inside_quotes = 1'b1;
    end else begin
      r = push(r, KIND_BYTE, q);
    end
    return r;
  endfunction

  // A byte with nothing held: quote and escape bytes wait for lookahead.
  function automatic tok_ctx_t fresh_byte(tok_ctx_t c, tok_cfg_t g, logic [7:0] b);
    tok_ctx_t r;
    logic     esc_on;
    r      = c;
    esc_on = (g.quote_char != g.escape_char);
    if ((esc_on && b == g.escape_char) || b == g.quote_char) begin
      r.st.held_byte  = b;
      r.st.held_valid = 1'b1;
    end else begin
      r = plain_byte(r, g, b);
    end
    return r;
  endfunction

  // Settle a held byte when the line or the stream ends.
  function automatic tok_ctx_t resolve_held(tok_ctx_t c, tok_cfg_t g);
    tok_ctx_t r;
    r = c;
    if (c.st.held_valid) begin
      r.st.held_valid = 1'b0;
      if (c.st.held_byte == g.quote_char) begin
        r = lone_quote(r, c.st.held_byte);
      end else begin
        r = plain_byte(r, g, c.st.held_byte);
      end
    end
    return r;
  endfunction

  // A content byte of the line, resolved against any held byte.
  function automatic tok_ctx_t content_byte(tok_ctx_t c, tok_cfg_t g, logic [7:0] b);
    tok_ctx_t   r;
    logic [7:0] h;
    logic       esc_on;
    r      = c;
    h      = c.st.held_byte;
    esc_on = (g.quote_char != g.escape_char);
    r.st.line_not_empty = 1'b1;
    if (!c.st.held_valid) begin
      r = fresh_byte(r, g, b);
    end else begin
      r.st.held_valid = 1'b0;
      if (esc_on && h == g.escape_char) begin
        r = push(r, KIND_BYTE, b);
      end else if (h == g.quote_char && b == g.quote_char) begin
        if (c.st.inside_quotes) begin
          r = push(r, KIND_BYTE, b);
        end else begin
          r.st.inside_quotes = 1'b1;
          r.st.held_byte     = b;
          r.st.held_valid    = 1'b1;
        end
      end else if (h == g.quote_char) begin
        r = lone_quote(r, h);
        r = fresh_byte(r, g, b);
      end else begin
        r = plain_byte(r, g, h);
        r = fresh_byte(r, g, b);
      end
    end
    return r;
  endfunction

  // Top-level decode of one beat.
  always_comb begin
    tok_ctx_t c;
    c     = '0;
    c.st  = st;
    if (end_of_input) begin
      c = resolve_held(c, cfg);
      if (c.st.inside_quotes) begin
        c = push(c, KIND_QUOTE_ERROR, 8'h00);
      end else if (c.st.line_not_empty) begin
        c = push(c, KIND_RECORD_END, 8'h00);
      end
      c.st = TOK_STATE_RESET;
    end else if (data_byte == CH_NUL) begin
      c.st.after_cr = 1'b0;
    end else if (data_byte == CH_LF && st.after_cr) begin
      c.st.after_cr = 1'b0;
    end else if (data_byte == CH_LF || data_byte == CH_CR) begin
      c = resolve_held(c, cfg);
      if (c.st.inside_quotes) begin
        c = push(c, KIND_BYTE, CH_LF);
      end else begin
        c = push(c, KIND_RECORD_END, 8'h00);
      end
      c.st.at_field_start = 1'b1;
      c.st.line_not_empty = 1'b0;
      c.st.after_cr       = (data_byte == CH_CR);
    end else begin
      c.st.after_cr = 1'b0;
      c = content_byte(c, cfg, data_byte);
    end
    // Mark the final result of this beat.
    if (c.res.count == 2'd1) begin
      c.res.item0.last = 1'b1;
    end
    if (c.res.count == 2'd2) begin
      c.res.item1.last = 1'b1;
    end
    state_next = c.st;
    res        = c.res;
  end

endmodule

### rtl/csvtok_queue.sv
// ----------------------------------------------------------------------------
// CSV tokenizer result queue
// Small register FIFO that takes up to two results per cycle and hands one
// result per cycle to the output channel whenever it pops.
// ----------------------------------------------------------------------------
module csvtok_queue
  import csvtok_pkg::*;
#(
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_count,
  input  res_item_t     push_item0,
  input  res_item_t     push_item1,
  input  logic          pop,
  output res_item_t     head,
  output logic [CW-1:0] count
);

  res_item_t         mem [DEPTH];
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     wr_ptr_next;
  logic [PW-1:0]     wr_ptr_inc;
  logic [CW-1:0]     count_next;

  function automatic logic [PW-1:0] next_ptr(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_inc = next_ptr(wr_ptr);

  // Write pointer advance by the number of results pushed.
  always_comb begin
    unique case (push_count)
      2'd1:    wr_ptr_next = wr_ptr_inc;
      2'd2:    wr_ptr_next = next_ptr(wr_ptr_inc);
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  assign count_next = count + CW'(push_count) - CW'(pop);

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_item0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_inc] <= push_item1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= next_ptr(rd_ptr);
      end
    end
  end

  assign head = mem[rd_ptr];

endmodule

### rtl/csv_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// Splits a raw byte stream into field bytes, field ends and record ends.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one raw byte (data_byte) or an end-of-input marker
//   (end_of_input). Output beats carry one result: kind, value and last,
//   where last flags the final result caused by one input beat. Both
//   channels use valid/stall; a beat moves when valid is high and stall low.
//   The configuration channel writes delimiter, quote and escape bytes by
//   index; it is always ready. The user must write it only while the
//   block is idle; the block does not enforce this. One input beat is
//   taken every cycle while in_stall is low. An accepted beat is held in
//   the input register, decoded by the step logic once the queue has room
//   for two results and written into the result queue. A beat makes zero,
//   one or two results; the output side drains one per cycle while
//   out_stall is low, so the sustained input rate is one per cycle as long
//   as the results per beat average at most one. in_stall rises when the
//   queue lacks room for two more results and the input register is full;
//   a stalled receiver therefore backs up into the input channel. Reset
//   clears the tokenizer state, empties the queue and restores the default
//   delimiter, quote and escape bytes.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core
  import csvtok_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // Input channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  // Output channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic       last,
  // Configuration channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tok_cfg_t        cfg;
  tok_state_t      st;
  tok_state_t      state_next;
  res_pair_t       step_res;
  res_item_t       head;
  logic [CW-1:0]   q_count;

  logic            in_full;
  logic [7:0]      in_byte;
  logic            in_eoi;
  logic            in_accept;
  logic            proc_go;
  logic            pop;
  logic [1:0]      push_count;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter_char <= DELIMITER_RESET;
      cfg.quote_char     <= QUOTE_RESET;
      cfg.escape_char    <= ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DELIMITER: cfg.delimiter_char <= cfg_data;
        REG_QUOTE:     cfg.quote_char     <= cfg_data;
        REG_ESCAPE:    cfg.escape_char    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The input register is decoded once the queue has room for two results.
  assign proc_go   = in_full && (q_count <= CW'(QUEUE_DEPTH - 2));
  assign in_stall  = in_full && !proc_go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (proc_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte <= data_byte;
      in_eoi  <= end_of_input;
    end
  end

  // Tokenizer state advances once per decoded beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= TOK_STATE_RESET;
    end else if (proc_go) begin
      st <= state_next;
    end
  end

  csvtok_step u_step (
    .cfg          (cfg),
    .st           (st),
    .data_byte    (in_byte),
    .end_of_input (in_eoi),
    .state_next   (state_next),
    .res          (step_res)
  );

  assign push_count = proc_go ? step_res.count : 2'd0;
  assign pop        = out_valid && !out_stall;

  csvtok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_item0 (step_res.item0),
    .push_item1 (step_res.item1),
    .pop        (pop),
    .head       (head),
    .count      (q_count)
  );

  // Output beat.
  assign out_valid = (q_count != '0);
  assign kind      = head.kind;
  assign value     = head.value;
  assign last      = head.last;

  // End of input always returns the tokenizer to its reset state.
  assert property (@(posedge clk) disable iff (rst)
    proc_go && in_eoi |=> st == TOK_STATE_RESET)
    else $error("tokenizer state not cleared after end of input");

  // The step logic never yields more than two results.
  assert property (@(posedge clk) disable iff (rst)
    proc_go |-> step_res.count != 2'd3)
    else $error("step produced an impossible result count");

  // The queue never overfills.
  assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // No output appears without a decoded beat to cause it.
  assert property (@(posedge clk) disable iff (rst)
    !proc_go && q_count == '0 |=> !out_valid)
    else $error("output valid without a pending result");

endmodule

### verif/csv_field_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Feeds the tokenizer core a directed table of bytes and then random CSV-like
// records under several delimiter, quote and escape settings. A predictor
// in this file tracks the tokenizer state and produces the expected result
// beats; each result beat is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
  import csvtok_pkg::*;

  localparam int PHASE_ITEMS = 90;
  localparam int LONG_HOLD   = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 12;

  // One row of the directed table. When typed is set, the row carries its
  // own expectation: either nothing or the single result in kind0/value0.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       typed;
    logic       one_res;
    logic [1:0] kind0;
    logic [7:0] value0;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [26] = '{
    '{8'hFF,           1'b0, 1'b1, 1'b1, KIND_BYTE,        8'hFF},
    '{DELIMITER_RESET, 1'b0, 1'b1, 1'b1, KIND_FIELD_END,   8'h00},
    '{CH_CR,           1'b0, 1'b1, 1'b1, KIND_RECORD_END,  8'h00},
    '{CH_LF,           1'b0, 1'b1, 1'b0, KIND_BYTE,        8'h00},
    '{CH_CR,           1'b0, 1'b1, 1'b1, KIND_RECORD_END,  8'h00},
    '{CH_NUL,          1'b0, 1'b1, 1'b0, KIND_BYTE,        8'h00},
    '{CH_LF,           1'b0, 1'b1, 1'b1, KIND_RECORD_END,  8'h00},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{8'h78,           1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{DELIMITER_RESET, 1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{CH_LF,           1'b0, 1'b1, 1'b1, KIND_BYTE,        CH_LF},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{DELIMITER_RESET, 1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{8'h62,           1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{ESCAPE_RESET,    1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{DELIMITER_RESET, 1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{ESCAPE_RESET,    1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{CH_LF,           1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{QUOTE_RESET,     1'b0, 1'b0, 1'b0, KIND_BYTE,        8'h00},
    '{8'hFF,           1'b1, 1'b1, 1'b1, KIND_QUOTE_ERROR, 8'h00},
    '{8'h00,           1'b1, 1'b1, 1'b0, KIND_BYTE,        8'h00}
  };

  logic       clk;
  logic       rst          = 1'b1;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte    = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index    = REG_DELIMITER;
  logic [7:0] cfg_data     = 8'h00;

  // Predictor copy of the registers and of the tokenizer state.
  logic [7:0] delim_chr  = DELIMITER_RESET;
  logic [7:0] quote_chr  = QUOTE_RESET;
  logic [7:0] esc_chr    = ESCAPE_RESET;
  logic       in_quotes  = 1'b0;
  logic       field_start = 1'b1;
  logic       hold_vld   = 1'b0;
  logic [7:0] hold_chr   = 8'h00;
  logic       cr_seen    = 1'b0;
  logic       line_used  = 1'b0;

  res_item_t  beat_results [$];
  res_item_t  pending_tokens [$];

  // Directed row currently offered, and run bookkeeping.
  logic       row_typed   = 1'b0;
  logic       row_one_res = 1'b0;
  logic [1:0] row_kind    = KIND_BYTE;
  logic [7:0] row_value   = 8'h00;
  logic       quiet       = 1'b0;
  int         hold_requests = 0;
  int         beats_in    = 0;
  int         cfg_writes  = 0;
  int         mismatches  = 0;
  int         idle_cycles = 0;

  csv_field_tokenizer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .value        (value),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer predictor
  // ---------------------------------------------------------------------------

  function automatic void put_result(input logic [1:0] k, input logic [7:0] v);
    res_item_t r;
    if (beat_results.size() >= 2) return;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    beat_results = {beat_results, r};
  endfunction

  function automatic logic escape_on();
    return quote_chr != esc_chr;
  endfunction

  function automatic void plain_char(input logic [7:0] c);
    field_start = 1'b0;
    if (c == delim_chr && !in_quotes) begin
      put_result(KIND_FIELD_END, 8'h00);
      field_start = 1'b1;
    end else begin
      put_result(KIND_BYTE, c);
    end
  endfunction

  // A quote that is not part of a doubled pair.
  function automatic void single_quote(input logic [7:0] q);
    if (in_quotes) in_quotes = 1'b0;
    else if (field_start) in_quotes = 1'b1;
    else put_result(KIND_BYTE, q);
  endfunction

  // Quotes and active escapes wait for the next byte before they are judged.
  function automatic void new_char(input logic [7:0] c);
    if ((escape_on() && c == esc_chr) || c == quote_chr) begin
      hold_chr = c;
      hold_vld = 1'b1;
    end else begin
      plain_char(c);
    end
  endfunction

  function automatic void resolve_held();
    logic [7:0] h;
    if (!hold_vld) return;
    h = hold_chr;
    hold_vld = 1'b0;
    if (h == quote_chr) single_quote(h);
    else plain_char(h);
  endfunction

  function automatic void content_char(input logic [7:0] c);
    logic [7:0] h;
    line_used = 1'b1;
    if (!hold_vld) begin
      new_char(c);
      return;
    end
    h = hold_chr;
    hold_vld = 1'b0;
    // An escape makes the byte literal without touching the field start.
    if (escape_on() && h == esc_chr) begin
      put_result(KIND_BYTE, c);
      return;
    end
    if (h == quote_chr) begin
      if (c == quote_chr) begin
        if (in_quotes) begin
          put_result(KIND_BYTE, c);
        end else begin
          in_quotes = 1'b1;
          hold_chr  = c;
          hold_vld  = 1'b1;
        end
        return;
      end
      single_quote(h);
    end else begin
      plain_char(h);
    end
    new_char(c);
  endfunction

  function automatic void clear_parser_state();
    in_quotes   = 1'b0;
    field_start = 1'b1;
    hold_vld    = 1'b0;
    hold_chr    = 8'h00;
    cr_seen     = 1'b0;
    line_used   = 1'b0;
  endfunction

  // Works out the result beats of one input beat into beat_results.
  function automatic void tokenize_beat(input logic [7:0] b, input logic eoi);
    res_item_t r;
    beat_results.delete();
    if (eoi) begin
      resolve_held();
      if (in_quotes) put_result(KIND_QUOTE_ERROR, 8'h00);
      else if (line_used) put_result(KIND_RECORD_END, 8'h00);
      clear_parser_state();
    end else if (b == CH_NUL) begin
      cr_seen = 1'b0;
    end else if (b == CH_LF && cr_seen) begin
      cr_seen = 1'b0;
    end else if (b == CH_LF || b == CH_CR) begin
      resolve_held();
      if (in_quotes) put_result(KIND_BYTE, CH_LF);
      else put_result(KIND_RECORD_END, 8'h00);
      field_start = 1'b1;
      line_used   = 1'b0;
      cr_seen     = (b == CH_CR);
    end else begin
      cr_seen = 1'b0;
      content_char(b);
    end
    if (beat_results.size() > 0) begin
      r = beat_results[beat_results.size() - 1];
      r.last = 1'b1;
      beat_results[beat_results.size() - 1] = r;
    end
  endfunction

  function automatic void check_field(input string fname, input logic [7:0] want_v,
                                      input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want_v, got_v);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks result beats and predicts on accepted input beats.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_item_t want;
    if (!rst) begin
      // The output is checked first so a new expectation never meets it.
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected result beat: kind %0d, value %0h, last %0b",
                   $time, kind, value, last);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("kind", {6'd0, want.kind}, {6'd0, kind});
          check_field("value", want.value, value);
          check_field("last", {7'd0, want.last}, {7'd0, last});
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DELIMITER: delim_chr = cfg_data;
          REG_QUOTE:     quote_chr = cfg_data;
          REG_ESCAPE:    esc_chr   = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        tokenize_beat(data_byte, end_of_input);
        if (row_typed) begin
          if (row_one_res) begin
            want.kind  = row_kind;
            want.value = row_value;
            want.last  = 1'b1;
            pending_tokens = {pending_tokens, want};
          end
        end else begin
          foreach (beat_results[i]) pending_tokens = {pending_tokens, beat_results[i]};
        end
        beats_in++;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off per request, none when
  // the run is in its quiet part.
  initial begin
    int holds_done;
    holds_done = 0;
    @(negedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one input beat, after an optional gap, and returns at the falling
  // edge that follows its acceptance with valid still high.
  task automatic put_beat(input logic [7:0] b, input logic eoi);
    int taken;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    end_of_input <= eoi;
    taken = beats_in;
    do @(negedge clk); while (beats_in == taken);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    int done;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    done = cfg_writes;
    do @(negedge clk); while (cfg_writes == done);
  endtask

  task automatic set_config(input logic [7:0] d, input logic [7:0] q, input logic [7:0] e);
    write_reg(REG_DELIMITER, d);
    write_reg(REG_QUOTE, q);
    write_reg(REG_ESCAPE, e);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits until every expected result has come, then lets
  // the pipeline settle in case the last beats made no result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_sym();
    case ($urandom_range(0, 19))
      0, 1:    return delim_chr;
      2, 3:    return quote_chr;
      4:       return esc_chr;
      5:       return CH_LF;
      6:       return CH_CR;
      7:       return CH_NUL;
      8, 9:    return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  task automatic send_field_char(input logic quoted);
    logic [7:0] letter;
    letter = 8'($urandom_range(97, 122));
    case ($urandom_range(0, 11))
      0: begin
        put_beat(esc_chr, 1'b0);
        put_beat(8'($urandom_range(0, 255)), 1'b0);
      end
      1: begin
        put_beat(quote_chr, 1'b0);
        if (quoted) put_beat(quote_chr, 1'b0);
      end
      2: put_beat(quoted ? delim_chr : letter, 1'b0);
      3: begin
        if (quoted) put_beat(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR, 1'b0);
        else put_beat(letter, 1'b0);
      end
      4: put_beat(8'($urandom_range(0, 255)), 1'b0);
      default: put_beat(letter, 1'b0);
    endcase
  endtask

  // A well-formed record with random content, ended by one of the line ends
  // or by end of input, and now and then running into the next record.
  task automatic send_record();
    int n_fields;
    int n_chars;
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) put_beat(delim_chr, 1'b0);
      n_chars = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        put_beat(quote_chr, 1'b0);
        repeat (n_chars) send_field_char(1'b1);
        put_beat(quote_chr, 1'b0);
      end else begin
        repeat (n_chars) send_field_char(1'b0);
      end
    end
    case ($urandom_range(0, 7))
      0, 1, 2: put_beat(CH_LF, 1'b0);
      3, 4:    put_beat(CH_CR, 1'b0);
      5: begin
        put_beat(CH_CR, 1'b0);
        put_beat(CH_LF, 1'b0);
      end
      6:       put_beat(8'($urandom_range(0, 255)), 1'b1);
      default: ;
    endcase
  endtask

  // Short runs of loose symbols and stray end-of-input beats.
  task automatic send_noise();
    logic [7:0] b;
    logic       eoi;
    repeat ($urandom_range(1, 6)) begin
      b   = pick_sym();
      eoi = ($urandom_range(0, 11) == 0);
      put_beat(b, eoi);
    end
  endtask

  task automatic fill_random(input int n_beats);
    int stop_at;
    stop_at = beats_in + n_beats;
    while (beats_in < stop_at) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_record();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset register values.
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      row_typed   = DIR_ROWS[i].typed;
      row_one_res = DIR_ROWS[i].one_res;
      row_kind    = DIR_ROWS[i].kind0;
      row_value   = DIR_ROWS[i].value0;
      put_beat(DIR_ROWS[i].data, DIR_ROWS[i].eoi);
    end
    row_typed = 1'b0;
    fill_random(PHASE_ITEMS);
    drain_results();

    // Tab delimiter with escape equal to quote, so escaping is off. The
    // receiver holds off for a long stretch while records keep coming.
    set_config(8'h09, 8'h27, 8'h27);
    hold_requests++;
    fill_random(PHASE_ITEMS);
    drain_results();

    // Top delimiter, a quote byte that never arrives, escape on the delimiter.
    set_config(8'hFF, 8'h00, 8'hFF);
    fill_random(PHASE_ITEMS);
    drain_results();

    // Delimiter and escape on the dropped NUL byte, quote at the top value.
    set_config(8'h00, 8'hFF, 8'h00);
    fill_random(PHASE_ITEMS);
    drain_results();

    // Escape shares the delimiter byte with quoting active.
    set_config(8'h7C, 8'h22, 8'h7C);
    fill_random(PHASE_ITEMS);
    drain_results();

    // Back to the usual bytes, with no idling on either side.
    set_config(DELIMITER_RESET, QUOTE_RESET, ESCAPE_RESET);
    quiet = 1'b1;
    fill_random(PHASE_ITEMS);
    drain_results();

    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
rtl/csvtok_pkg.sv
rtl/csvtok_step.sv
rtl/csvtok_queue.sv
rtl/csv_field_tokenizer_core.sv
verif/csv_field_tokenizer_tb.sv
